@@ hdl/sjds_pkg.sv @@
// Shared constants, tables and types of the scan jump distance segmenter.
package sjds_pkg;

   // Scan and CORDIC sizing
   localparam int MAX_SCAN_SAMPLES = 4096;
   localparam int CORDIC_STAGES    = 16;
   localparam int ATAN_TABLE_LEN   = 24;

   localparam int INDEX_W   = $clog2(MAX_SCAN_SAMPLES);
   localparam int STEP_W    = $clog2(ATAN_TABLE_LEN);

   // Field widths
   localparam int RANGE_W    = 16;
   localparam int COUNT_W    = 13;
   localparam int OUT_IDX_W  = 12;
   localparam int ANGLE_W    = 32;
   localparam int ASTEP_W    = 31;
   localparam int JUMP_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Datapath widths
   localparam int CW        = 34;               // CORDIC x, y, z
   localparam int MAG_W     = CW - 1;
   localparam int PROD_W    = MAG_W + RANGE_W;  // range times |cos| or |sin|
   localparam int FRAC_BITS = 30;
   localparam int PT_W      = 18;               // point coordinate, mm
   localparam int DIFF_W    = PT_W + 1;
   localparam int ABS_W     = PT_W;
   localparam int SQ_W      = 2 * ABS_W;
   localparam int SUM_W     = SQ_W + 1;
   localparam int THR_W     = 2 * JUMP_W;

   localparam logic signed [CW-1:0]  GAIN_Q30       = CW'(652032874);
   localparam logic [PROD_W-1:0]     ROUND_HALF     = PROD_W'(1) << (FRAC_BITS - 1);
   localparam logic [COUNT_W-1:0]    SIZE_MAX_COUNT = '1;
   localparam logic [INDEX_W-1:0]    INDEX_LAST     = INDEX_W'(MAX_SCAN_SAMPLES - 1);
   localparam logic [ANGLE_W-1:0]    QUARTER_TURN   = 32'h4000_0000;
   localparam logic [ANGLE_W-1:0]    HALF_TURN      = 32'h8000_0000;
   localparam logic [ANGLE_W-1:0]    THREE_QUARTER  = 32'hC000_0000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_JUMP_DIST  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_POINTS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CEILING    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ANG_START  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ANG_STEP   = 3'd5;

   // Register reset values
   localparam logic [JUMP_W-1:0]  JUMP_RESET    = 16'd300;
   localparam logic [COUNT_W-1:0] MIN_RESET     = 13'd3;
   localparam logic [RANGE_W-1:0] FLOOR_RESET   = 16'd0;
   localparam logic [RANGE_W-1:0] CEILING_RESET = 16'hFFFF;
   localparam logic [ANGLE_W-1:0] ASTART_RESET  = 32'd0;
   localparam logic [ASTEP_W-1:0] ASTEP_RESET   = 31'd11930465;

   localparam logic [31:0] ATAN_TABLE [ATAN_TABLE_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ANGLE,
      ST_PREP,
      ST_ROTATE,
      ST_MAG,
      ST_SCALE,
      ST_ROUND,
      ST_DIFF,
      ST_SQUARE,
      ST_UPDATE,
      ST_CLOSE,
      ST_EMIT_A,
      ST_EMIT_B
   } state_type;

   typedef struct packed {
      logic [INDEX_W-1:0] first;
      logic [INDEX_W-1:0] last;
      logic [COUNT_W-1:0] size;
   } cluster_type;

endpackage

@@ hdl/scan_jump_distance_segmenter_top.sv @@
// Scan jump distance segmenter: polar to xy by CORDIC, gap test, cluster reports.
// Work from acceptance to the close step: angle multiply, pre-rotation, 16 CORDIC iterations,
//   magnitude, 16 bit-serial range multiply steps, then round, difference, square, update.
// One item in work: a new request is taken only while idle, after the close step and any
//   report, which stalls while rsp_ready is low; a loaded result waits while the next item starts.
// Reset (synchronous, active high) restores register defaults, clears index and cluster.
module scan_jump_distance_segmenter_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [sjds_pkg::RANGE_W-1:0]       req_range_mm,
   input  logic                               req_end_of_scan,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [sjds_pkg::OUT_IDX_W-1:0]     rsp_first_index,
   output logic [sjds_pkg::OUT_IDX_W-1:0]     rsp_last_index,
   output logic [sjds_pkg::COUNT_W-1:0]       rsp_point_count,
   output logic                               rsp_final_res,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sjds_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sjds_pkg::CSR_DATA_W-1:0]    csr_data
);
   import sjds_pkg::*;

   // ---------------------------------------------------------------- state
   state_type state_ff, state_in;

   // configuration registers
   logic [JUMP_W-1:0]  jump_ff,    jump_in;
   logic [COUNT_W-1:0] min_ff,     min_in;
   logic [RANGE_W-1:0] floor_ff,   floor_in;
   logic [RANGE_W-1:0] ceil_ff,    ceil_in;
   logic [ANGLE_W-1:0] astart_ff,  astart_in;
   logic [ASTEP_W-1:0] astep_ff,   astep_in;

   // scan and cluster state
   logic [INDEX_W-1:0]     sample_index_ff, sample_index_in;
   logic                   have_point_ff,   have_point_in;
   logic signed [PT_W-1:0] prev_x_ff, prev_x_in;
   logic signed [PT_W-1:0] prev_y_ff, prev_y_in;
   cluster_type            cluster_ff, cluster_in;

   // item in work
   logic [RANGE_W-1:0]      range_ff, range_in;
   logic                    eos_ff, eos_in;
   logic [ANGLE_W-1:0]      angle_ff, angle_in;
   logic                    flip_ff, flip_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic signed [CW-1:0]    x_ff, x_in;
   logic signed [CW-1:0]    y_ff, y_in;
   logic signed [CW-1:0]    z_ff, z_in;
   logic [MAG_W-1:0]        mag_x_ff, mag_x_in;
   logic [MAG_W-1:0]        mag_y_ff, mag_y_in;
   logic                    neg_x_ff, neg_x_in;
   logic                    neg_y_ff, neg_y_in;
   logic [RANGE_W-1:0]      range_sh_ff, range_sh_in;
   logic [PROD_W-1:0]       acc_x_ff, acc_x_in;
   logic [PROD_W-1:0]       acc_y_ff, acc_y_in;
   logic signed [PT_W-1:0]  pt_x_ff, pt_x_in;
   logic signed [PT_W-1:0]  pt_y_ff, pt_y_in;
   logic [ABS_W-1:0]        abs_x_ff, abs_x_in;
   logic [ABS_W-1:0]        abs_y_ff, abs_y_in;
   logic [SQ_W-1:0]         sq_x_ff, sq_x_in;
   logic [SQ_W-1:0]         sq_y_ff, sq_y_in;
   logic [THR_W-1:0]        thr_ff, thr_in;

   // pending reports: A from a jump, B from the end of a scan
   logic        a_flag_ff, a_flag_in;
   logic        b_flag_ff, b_flag_in;
   cluster_type rep_a_ff, rep_a_in;
   cluster_type rep_b_ff, rep_b_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_IDX_W-1:0] rsp_first_ff, rsp_first_in;
   logic [OUT_IDX_W-1:0] rsp_last_ff,  rsp_last_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                 rsp_final_ff, rsp_final_in;

   // ---------------------------------------------------------------- helpers
   logic                         in_window;
   logic                         slot_free;
   logic                         load_a;
   logic                         load_b;
   logic                         close_report;
   logic [INDEX_W+ASTEP_W-1:0]   angle_prod;
   logic [ANGLE_W-1:0]           angle_turned;
   logic signed [CW-1:0]         atan_step;
   logic signed [CW-1:0]         x_shr;
   logic signed [CW-1:0]         y_shr;
   logic [PROD_W-1:0]            rnd_x;
   logic [PROD_W-1:0]            rnd_y;
   logic [PT_W-1:0]              r_x;
   logic [PT_W-1:0]              r_y;
   logic signed [DIFF_W-1:0]     dif_x;
   logic signed [DIFF_W-1:0]     dif_y;
   logic [DIFF_W-1:0]            mag_dif_x;
   logic [DIFF_W-1:0]            mag_dif_y;
   logic [SUM_W-1:0]             dist_sq;
   logic                         jump_seen;

   assign in_window    = (req_range_mm >= floor_ff) && (req_range_mm <= ceil_ff);
   assign close_report = eos_ff && have_point_ff && (cluster_ff.size >= min_ff);

   assign angle_prod   = sample_index_ff * astep_ff;
   // angles in the left half plane get a half turn, results negated later
   assign angle_turned = angle_ff ^ HALF_TURN;

   assign atan_step = signed'(CW'(ATAN_TABLE[step_ff]));
   assign x_shr     = x_ff >>> step_ff;
   assign y_shr     = y_ff >>> step_ff;

   // round to nearest, ties away from zero, on the magnitude
   assign rnd_x = acc_x_ff + ROUND_HALF;
   assign rnd_y = acc_y_ff + ROUND_HALF;
   assign r_x   = rnd_x[FRAC_BITS +: PT_W];
   assign r_y   = rnd_y[FRAC_BITS +: PT_W];

   assign dif_x     = DIFF_W'(pt_x_ff) - DIFF_W'(prev_x_ff);
   assign dif_y     = DIFF_W'(pt_y_ff) - DIFF_W'(prev_y_ff);
   assign mag_dif_x = dif_x[DIFF_W-1] ? DIFF_W'(-dif_x) : DIFF_W'(dif_x);
   assign mag_dif_y = dif_y[DIFF_W-1] ? DIFF_W'(-dif_y) : DIFF_W'(dif_y);

   assign dist_sq   = SUM_W'(sq_x_ff) + SUM_W'(sq_y_ff);
   assign jump_seen = have_point_ff && (dist_sq > SUM_W'(thr_ff));

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = in_window ? ST_ANGLE : ST_CLOSE;
            end
         end
         ST_ANGLE:  state_in = ST_PREP;
         ST_PREP:   state_in = ST_ROTATE;
         ST_ROTATE: begin
            if (step_ff == STEP_W'(CORDIC_STAGES - 1)) begin
               state_in = ST_MAG;
            end
         end
         ST_MAG:    state_in = ST_SCALE;
         ST_SCALE: begin
            if (step_ff == STEP_W'(RANGE_W - 1)) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND:  state_in = ST_DIFF;
         ST_DIFF:   state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_CLOSE;
         ST_CLOSE: begin
            if (a_flag_ff) begin
               state_in = ST_EMIT_A;
            end else if (close_report) begin
               state_in = ST_EMIT_B;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_A: begin
            if (slot_free) begin
               state_in = b_flag_ff ? ST_EMIT_B : ST_IDLE;
            end
         end
         ST_EMIT_B: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- outputs of the FSM
   always_comb begin
      slot_free = !rsp_valid_ff || rsp_ready;
      req_ready = (state_ff == ST_IDLE);
      load_a    = (state_ff == ST_EMIT_A) && slot_free;
      load_b    = (state_ff == ST_EMIT_B) && slot_free;
   end

   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------- datapath
   always_comb begin
      jump_in         = jump_ff;
      min_in          = min_ff;
      floor_in        = floor_ff;
      ceil_in         = ceil_ff;
      astart_in       = astart_ff;
      astep_in        = astep_ff;
      sample_index_in = sample_index_ff;
      have_point_in   = have_point_ff;
      prev_x_in       = prev_x_ff;
      prev_y_in       = prev_y_ff;
      cluster_in      = cluster_ff;
      range_in        = range_ff;
      eos_in          = eos_ff;
      angle_in        = angle_ff;
      flip_in         = flip_ff;
      step_in         = step_ff;
      x_in            = x_ff;
      y_in            = y_ff;
      z_in            = z_ff;
      mag_x_in        = mag_x_ff;
      mag_y_in        = mag_y_ff;
      neg_x_in        = neg_x_ff;
      neg_y_in        = neg_y_ff;
      range_sh_in     = range_sh_ff;
      acc_x_in        = acc_x_ff;
      acc_y_in        = acc_y_ff;
      pt_x_in         = pt_x_ff;
      pt_y_in         = pt_y_ff;
      abs_x_in        = abs_x_ff;
      abs_y_in        = abs_y_ff;
      sq_x_in         = sq_x_ff;
      sq_y_in         = sq_y_ff;
      thr_in          = thr_ff;
      a_flag_in       = a_flag_ff;
      b_flag_in       = b_flag_ff;
      rep_a_in        = rep_a_ff;
      rep_b_in        = rep_b_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_first_in    = rsp_first_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_final_in    = rsp_final_ff;

      // register writes are to arrive only while idle; the block itself does not enforce this
      if (csr_valid) begin
         case (csr_index)
            CSR_JUMP_DIST:  jump_in   = csr_data[JUMP_W-1:0];
            CSR_MIN_POINTS: min_in    = csr_data[COUNT_W-1:0];
            CSR_FLOOR:      floor_in  = csr_data[RANGE_W-1:0];
            CSR_CEILING:    ceil_in   = csr_data[RANGE_W-1:0];
            CSR_ANG_START:  astart_in = csr_data[ANGLE_W-1:0];
            CSR_ANG_STEP:   astep_in  = csr_data[ASTEP_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               range_in  = req_range_mm;
               eos_in    = req_end_of_scan;
               a_flag_in = 1'b0;
            end
         end
         ST_ANGLE: begin
            angle_in = astart_ff + angle_prod[ANGLE_W-1:0];
         end
         ST_PREP: begin
            flip_in = (angle_ff > QUARTER_TURN) && (angle_ff < THREE_QUARTER);
            z_in    = flip_in ? CW'(signed'(angle_turned)) : CW'(signed'(angle_ff));
            x_in    = GAIN_Q30;
            y_in    = '0;
            step_in = '0;
         end
         ST_ROTATE: begin
            if (!z_ff[CW-1]) begin
               x_in = x_ff - y_shr;
               y_in = y_ff + x_shr;
               z_in = z_ff - atan_step;
            end else begin
               x_in = x_ff + y_shr;
               y_in = y_ff - x_shr;
               z_in = z_ff + atan_step;
            end
            step_in = step_ff + 1'b1;
         end
         ST_MAG: begin
            // the half turn flips the sign only; the magnitude is unchanged
            mag_x_in    = x_ff[CW-1] ? MAG_W'(-x_ff) : MAG_W'(x_ff);
            mag_y_in    = y_ff[CW-1] ? MAG_W'(-y_ff) : MAG_W'(y_ff);
            neg_x_in    = x_ff[CW-1] ^ flip_ff;
            neg_y_in    = y_ff[CW-1] ^ flip_ff;
            range_sh_in = range_ff;
            acc_x_in    = '0;
            acc_y_in    = '0;
            step_in     = '0;
         end
         ST_SCALE: begin
            // range bits MSB first, one per cycle
            acc_x_in    = (acc_x_ff << 1) + (range_sh_ff[RANGE_W-1] ? PROD_W'(mag_x_ff) : '0);
            acc_y_in    = (acc_y_ff << 1) + (range_sh_ff[RANGE_W-1] ? PROD_W'(mag_y_ff) : '0);
            range_sh_in = range_sh_ff << 1;
            step_in     = step_ff + 1'b1;
         end
         ST_ROUND: begin
            pt_x_in = neg_x_ff ? signed'(PT_W'(0) - r_x) : signed'(r_x);
            pt_y_in = neg_y_ff ? signed'(PT_W'(0) - r_y) : signed'(r_y);
         end
         ST_DIFF: begin
            abs_x_in = mag_dif_x[ABS_W-1:0];
            abs_y_in = mag_dif_y[ABS_W-1:0];
         end
         ST_SQUARE: begin
            sq_x_in = abs_x_ff * abs_x_ff;
            sq_y_in = abs_y_ff * abs_y_ff;
            thr_in  = jump_ff * jump_ff;
         end
         ST_UPDATE: begin
            if (jump_seen) begin
               rep_a_in         = cluster_ff;
               a_flag_in        = (cluster_ff.size >= min_ff);
               cluster_in.first = sample_index_ff;
               cluster_in.size  = COUNT_W'(1);
            end else if (have_point_ff) begin
               if (cluster_ff.size != SIZE_MAX_COUNT) begin
                  cluster_in.size = cluster_ff.size + 1'b1;
               end
            end else begin
               cluster_in.first = sample_index_ff;
               cluster_in.size  = COUNT_W'(1);
            end
            cluster_in.last = sample_index_ff;
            prev_x_in       = pt_x_ff;
            prev_y_in       = pt_y_ff;
            have_point_in   = 1'b1;
         end
         ST_CLOSE: begin
            b_flag_in = close_report;
            rep_b_in  = cluster_ff;
            if (eos_ff) begin
               have_point_in   = 1'b0;
               cluster_in      = '0;
               sample_index_in = '0;
            end else if (sample_index_ff != INDEX_LAST) begin
               sample_index_in = sample_index_ff + 1'b1;
            end
         end
         default: ;
      endcase

      // result register
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_a) begin
         rsp_valid_in = 1'b1;
         rsp_first_in = OUT_IDX_W'(rep_a_ff.first);
         rsp_last_in  = OUT_IDX_W'(rep_a_ff.last);
         rsp_count_in = rep_a_ff.size;
         rsp_final_in = !b_flag_ff;
      end else if (load_b) begin
         rsp_valid_in = 1'b1;
         rsp_first_in = OUT_IDX_W'(rep_b_ff.first);
         rsp_last_in  = OUT_IDX_W'(rep_b_ff.last);
         rsp_count_in = rep_b_ff.size;
         rsp_final_in = 1'b1;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         jump_ff         <= JUMP_RESET;
         min_ff          <= MIN_RESET;
         floor_ff        <= FLOOR_RESET;
         ceil_ff         <= CEILING_RESET;
         astart_ff       <= ASTART_RESET;
         astep_ff        <= ASTEP_RESET;
         sample_index_ff <= '0;
         have_point_ff   <= 1'b0;
         prev_x_ff       <= '0;
         prev_y_ff       <= '0;
         cluster_ff      <= '0;
         a_flag_ff       <= 1'b0;
         b_flag_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         jump_ff         <= jump_in;
         min_ff          <= min_in;
         floor_ff        <= floor_in;
         ceil_ff         <= ceil_in;
         astart_ff       <= astart_in;
         astep_ff        <= astep_in;
         sample_index_ff <= sample_index_in;
         have_point_ff   <= have_point_in;
         prev_x_ff       <= prev_x_in;
         prev_y_ff       <= prev_y_in;
         cluster_ff      <= cluster_in;
         a_flag_ff       <= a_flag_in;
         b_flag_ff       <= b_flag_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      range_ff     <= range_in;
      eos_ff       <= eos_in;
      angle_ff     <= angle_in;
      flip_ff      <= flip_in;
      step_ff      <= step_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      z_ff         <= z_in;
      mag_x_ff     <= mag_x_in;
      mag_y_ff     <= mag_y_in;
      neg_x_ff     <= neg_x_in;
      neg_y_ff     <= neg_y_in;
      range_sh_ff  <= range_sh_in;
      acc_x_ff     <= acc_x_in;
      acc_y_ff     <= acc_y_in;
      pt_x_ff      <= pt_x_in;
      pt_y_ff      <= pt_y_in;
      abs_x_ff     <= abs_x_in;
      abs_y_ff     <= abs_y_in;
      sq_x_ff      <= sq_x_in;
      sq_y_ff      <= sq_y_in;
      thr_ff       <= thr_in;
      rep_a_ff     <= rep_a_in;
      rep_b_ff     <= rep_b_in;
      rsp_first_ff <= rsp_first_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_count_ff <= rsp_count_in;
      rsp_final_ff <= rsp_final_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_first_index = rsp_first_ff;
   assign rsp_last_index  = rsp_last_ff;
   assign rsp_point_count = rsp_count_ff;
   assign rsp_final_res   = rsp_final_ff;

   // ---------------------------------------------------------------- assertions
   a_rotate_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROTATE) |-> (step_ff < STEP_W'(CORDIC_STAGES)))
      else $error("CORDIC iteration count out of range");

   a_open_size: assert property (@(posedge clock) disable iff (reset)
      have_point_ff |-> (cluster_ff.size != '0))
      else $error("open cluster with zero points");

   a_index_order: assert property (@(posedge clock) disable iff (reset)
      have_point_ff |-> (cluster_ff.first <= cluster_ff.last))
      else $error("cluster first index beyond last index");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != ST_IDLE))
      else $error("accepted item did not start work");

endmodule
